// ===== sv/tnvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tnvc_pkg: typed numeric comparator package
// Type codes, result codes, and the exact int64 / double ordering helpers.
// ----------------------------------------------------------------------------
package tnvc_pkg;

	typedef enum logic [1:0] {
		T_NULL = 2'd0,
		T_BOOL = 2'd1,
		T_INT  = 2'd2,
		T_DBL  = 2'd3
	} vtype_t;

	typedef enum logic [1:0] {
		ORD_LESS      = 2'd0,
		ORD_EQUAL     = 2'd1,
		ORD_GREATER   = 2'd2,
		ORD_UNORDERED = 2'd3
	} ord_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_NAN      = 2'd1,
		ERR_INCOMPAT = 2'd2,
		ERR_RSVD     = 2'd3
	} err_t;

	localparam logic ACT_ORDER = 1'b0;
	localparam logic ACT_EQUAL = 1'b1;

	typedef struct packed {
		logic [1:0]  order_code;
		logic        is_equal;
		logic [1:0]  error_code;
	} result_t;

	function automatic logic is_nan(input logic [63:0] b);
		is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
	endfunction

	function automatic ord_t cmp_u(input logic [63:0] a, input logic [63:0] b);
		if (a < b)
			cmp_u = ORD_LESS;
		else if (a > b)
			cmp_u = ORD_GREATER;
		else
			cmp_u = ORD_EQUAL;
	endfunction

	function automatic ord_t flip(input ord_t o);
		unique case (o)
			ORD_LESS:    flip = ORD_GREATER;
			ORD_GREATER: flip = ORD_LESS;
			default:     flip = o;
		endcase
	endfunction

	// double vs double, not NaN; -0 == +0
	function automatic ord_t cmp_dd(input logic [63:0] a, input logic [63:0] b);
		logic az, bz;
		az = (a[62:0] == 63'd0);
		bz = (b[62:0] == 63'd0);
		if (az && bz)
			cmp_dd = ORD_EQUAL;
		else if (a[63] != b[63])
			cmp_dd = a[63] ? ORD_LESS : ORD_GREATER;
		else if (!a[63])
			cmp_dd = cmp_u({1'b0, a[62:0]}, {1'b0, b[62:0]});
		else
			cmp_dd = cmp_u({1'b0, b[62:0]}, {1'b0, a[62:0]});
	endfunction

	// exact int64 vs double (double not NaN)
	function automatic ord_t cmp_id(input logic [63:0] iv, input logic [63:0] f);
		logic [10:0]  e;
		logic [52:0]  m;
		logic [63:0]  mag;
		logic         frac;
		logic [11:0]  sh;
		logic [116:0] wide;
		logic [63:0]  imag;
		ord_t         mo;
		e    = f[62:52];
		m    = {(e != 11'd0), f[51:0]};
		mag  = 64'd0;
		frac = 1'b0;
		wide = 117'd0;
		sh   = 12'd0;
		imag = iv[63] ? (~iv + 64'd1) : iv;
		if (e >= 11'd1086) begin
			// |f| >= 2^63
			if (f[63] && e == 11'd1086 && f[51:0] == 52'd0)
				cmp_id = (iv == 64'h8000_0000_0000_0000) ? ORD_EQUAL : ORD_GREATER;
			else
				cmp_id = f[63] ? ORD_GREATER : ORD_LESS;
		end else begin
			if (e >= 11'd1075) begin
				sh  = {1'b0, e} - 12'd1075;
				mag = 64'(m) << sh[3:0] << (sh[5:4] * 16);
			end else if (e >= 11'd1023) begin
				sh   = 12'd1075 - {1'b0, e};
				wide = {m, 64'd0} >> sh[5:0];
				mag  = {11'd0, wide[116:64]};
				frac = (wide[63:0] != 64'd0);
			end else begin
				mag  = 64'd0;
				frac = (f[62:0] != 63'd0);
			end
			if (mag == 64'd0 && !frac)
				cmp_id = iv[63] ? ORD_LESS : ((iv == 64'd0) ? ORD_EQUAL : ORD_GREATER);
			else if (iv[63] != f[63] && !(iv == 64'd0))
				cmp_id = iv[63] ? ORD_LESS : ORD_GREATER;
			else if (iv == 64'd0)
				cmp_id = f[63] ? ORD_GREATER : ORD_LESS;
			else begin
				mo = cmp_u(imag, mag);
				if (mo == ORD_EQUAL && frac)
					mo = ORD_LESS;
				cmp_id = iv[63] ? flip(mo) : mo;
			end
		end
	endfunction

endpackage
`default_nettype wire

// ===== sv/tnvc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tnvc_core: comparison logic
// Combinational typed compare of one request, from input register to result.
// ----------------------------------------------------------------------------
module tnvc_core (
	input  wire logic                  action,
	input  wire logic [1:0]            lhs_type,
	input  wire logic [63:0]           lhs_bits,
	input  wire logic [1:0]            rhs_type,
	input  wire logic [63:0]           rhs_bits,
	output tnvc_pkg::result_t          res
);
	logic lnum, rnum, nan, lnull, rnull, lbool, rbool;
	tnvc_pkg::ord_t nord;
	tnvc_pkg::ord_t ord;
	tnvc_pkg::err_t err;
	logic eq;

	assign lnull = (lhs_type == tnvc_pkg::T_NULL);
	assign rnull = (rhs_type == tnvc_pkg::T_NULL);
	assign lbool = (lhs_type == tnvc_pkg::T_BOOL);
	assign rbool = (rhs_type == tnvc_pkg::T_BOOL);
	assign lnum  = (lhs_type == tnvc_pkg::T_INT) || (lhs_type == tnvc_pkg::T_DBL);
	assign rnum  = (rhs_type == tnvc_pkg::T_INT) || (rhs_type == tnvc_pkg::T_DBL);
	assign nan = ((lhs_type == tnvc_pkg::T_DBL) && tnvc_pkg::is_nan(lhs_bits))
		|| ((rhs_type == tnvc_pkg::T_DBL) && tnvc_pkg::is_nan(rhs_bits));

	always_comb begin
		if (lhs_type == tnvc_pkg::T_INT && rhs_type == tnvc_pkg::T_INT)
			nord = tnvc_pkg::cmp_u({~lhs_bits[63], lhs_bits[62:0]},
				{~rhs_bits[63], rhs_bits[62:0]});
		else if (lhs_type == tnvc_pkg::T_DBL && rhs_type == tnvc_pkg::T_DBL)
			nord = tnvc_pkg::cmp_dd(lhs_bits, rhs_bits);
		else if (lhs_type == tnvc_pkg::T_INT)
			nord = tnvc_pkg::cmp_id(lhs_bits, rhs_bits);
		else
			nord = tnvc_pkg::flip(tnvc_pkg::cmp_id(rhs_bits, lhs_bits));
	end

	always_comb begin
		ord = tnvc_pkg::ORD_UNORDERED;
		eq  = 1'b0;
		err = tnvc_pkg::ERR_NONE;
		if (action == tnvc_pkg::ACT_ORDER) begin
			if (lnull || rnull) begin
				ord = tnvc_pkg::ORD_UNORDERED;
			end else if (lbool || rbool) begin
				err = tnvc_pkg::ERR_INCOMPAT;
			end else if (nan) begin
				err = tnvc_pkg::ERR_NAN;
			end else begin
				ord = nord;
			end
		end else begin
			if (lnull && rnull) begin
				eq = 1'b1;
			end else if (lnull || rnull) begin
				eq = 1'b0;
			end else if (lnum && rnum) begin
				if (nan)
					err = tnvc_pkg::ERR_NAN;
				else
					eq = (nord == tnvc_pkg::ORD_EQUAL);
			end else if (lbool && rbool) begin
				eq = (lhs_bits[0] == rhs_bits[0]);
			end else begin
				err = tnvc_pkg::ERR_INCOMPAT;
			end
		end
		res.order_code = ord;
		res.is_equal   = eq;
		res.error_code = err;
	end
endmodule
`default_nettype wire

// ===== sv/typed_numeric_value_comparator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// typed_numeric_value_comparator_unit: typed value compare
// Orders or equality-tests two typed operands (null/bool/int64/double).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action and both typed operands.
//   Output channel (out_valid/out_ready) carries order_code, is_equal and
//   error_code, one result per request.
//   Path: an accepted request is held in the input register, and its result
//   is then loaded into the result register, which drives out_valid and the
//   result outputs.
//   Throughput: one request per cycle; each stage can load and unload in the
//   same cycle, so nothing but a stalled receiver slows the flow.
//   Stall: a stage advances when the stage after it is empty or moving, so a
//   stalled receiver holds the result and back-pressure reaches in_ready.
//   Reset: arst_n clears both valid flags; no request is in flight after it.
// ----------------------------------------------------------------------------
module typed_numeric_value_comparator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        action,
	input  wire logic [1:0]  lhs_type,
	input  wire logic [63:0] lhs_bits,
	input  wire logic [1:0]  rhs_type,
	input  wire logic [63:0] rhs_bits,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [1:0]  order_code,
	output      logic        is_equal,
	output      logic [1:0]  error_code
);
	logic        v_s1, v_s2;
	logic        act_s1;
	logic [1:0]  lt_s1, rt_s1;
	logic [63:0] lb_s1, rb_s1;
	tnvc_pkg::result_t res_c, res_s2;
	logic adv2, adv1;

	assign adv2     = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv2;
	assign adv1     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (!v_s2 || out_ready)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			act_s1 <= action;
			lt_s1  <= lhs_type;
			lb_s1  <= lhs_bits;
			rt_s1  <= rhs_type;
			rb_s1  <= rhs_bits;
		end
		if (adv2)
			res_s2 <= res_c;
	end

	tnvc_core u_core (
		.action   (act_s1),
		.lhs_type (lt_s1),
		.lhs_bits (lb_s1),
		.rhs_type (rt_s1),
		.rhs_bits (rb_s1),
		.res      (res_c)
	);

	assign out_valid  = v_s2;
	assign order_code = res_s2.order_code;
	assign is_equal   = res_s2.is_equal;
	assign error_code = res_s2.error_code;

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != tnvc_pkg::ERR_NONE |->
		order_code == tnvc_pkg::ORD_UNORDERED && !is_equal)
		else $error("error result carries a compare value");
	a_eq_unord: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_equal |-> order_code == tnvc_pkg::ORD_UNORDERED)
		else $error("equality result with ordering code");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_s2))
		else $error("stalled result changed");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> v_s2)
		else $error("request lost between stages");
endmodule
`default_nettype wire

// ===== sim/typed_numeric_value_comparator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// typed_numeric_value_comparator_unit_tb: self-checking bench
// Directed and random typed operand pairs (null, bool, int64, double) are fed
// through the valid/ready request channel. Each request's expected result is
// predicted on acceptance and checked in order against the result channel,
// under random stalls on both sides, a long receiver hold-off and drains.
// ----------------------------------------------------------------------------
module typed_numeric_value_comparator_unit_tb;

	typedef struct {
		logic        action;
		logic [1:0]  lt;
		logic [63:0] lb;
		logic [1:0]  rt;
		logic [63:0] rb;
		bit          drain;
	} request_t;

	localparam logic [63:0] D_P63   = 64'h43E0_0000_0000_0000;
	localparam logic [63:0] D_N63   = 64'hC3E0_0000_0000_0000;
	localparam logic [63:0] D_PINF  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] D_NINF  = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] D_QNAN  = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] D_NZERO = 64'h8000_0000_0000_0000;
	localparam logic [63:0] D_P53   = 64'h4340_0000_0000_0000;
	localparam logic [63:0] D_1P5   = 64'h3FF8_0000_0000_0000;
	localparam logic [63:0] D_NEG1P5 = 64'hBFF8_0000_0000_0000;
	localparam logic [63:0] I_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] I_MIN   = 64'h8000_0000_0000_0000;
	localparam int LATE_AT = 340;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [1:0]  lhs_type = 2'd0;
	logic [63:0] lhs_bits = 64'd0;
	logic [1:0]  rhs_type = 2'd0;
	logic [63:0] rhs_bits = 64'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  order_code;
	logic        is_equal;
	logic [1:0]  error_code;

	request_t pend_q[$];
	tnvc_pkg::result_t expect_q[$];
	int n_sent = 0, n_got = 0, n_err = 0, n_nan = 0, n_incompat = 0, n_eqtrue = 0;
	int in_gap = 0, out_hold = 0, idle_cnt = 0;
	bit draining = 0;

	typed_numeric_value_comparator_unit DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit nan_bits(input logic [63:0] b);
		return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
	endfunction

	// exact integer vs double, double not NaN
	function automatic tnvc_pkg::ord_t int_vs_real(input longint iv, input real f);
		longint t;
		if (f < -9223372036854775808.0)
			return tnvc_pkg::ORD_GREATER;
		if (f >= 9223372036854775808.0)
			return tnvc_pkg::ORD_LESS;
		t = longint'(f);
		if (f >= 0.0 && real'(t) > f)
			t = t - 1;
		if (f < 0.0 && real'(t) < f)
			t = t + 1;
		if (iv < t)
			return tnvc_pkg::ORD_LESS;
		if (iv > t)
			return tnvc_pkg::ORD_GREATER;
		if (f > real'(t))
			return tnvc_pkg::ORD_LESS;
		if (f < real'(t))
			return tnvc_pkg::ORD_GREATER;
		return tnvc_pkg::ORD_EQUAL;
	endfunction

	function automatic tnvc_pkg::ord_t order_of_numbers(input tnvc_pkg::vtype_t a_t,
			input logic [63:0] a, input tnvc_pkg::vtype_t b_t, input logic [63:0] b);
		real ra, rb;
		tnvc_pkg::ord_t o;
		ra = $bitstoreal(a);
		rb = $bitstoreal(b);
		if (a_t == tnvc_pkg::T_INT && b_t == tnvc_pkg::T_INT)
			return $signed(a) < $signed(b) ? tnvc_pkg::ORD_LESS :
				($signed(a) > $signed(b) ? tnvc_pkg::ORD_GREATER : tnvc_pkg::ORD_EQUAL);
		if (a_t == tnvc_pkg::T_DBL && b_t == tnvc_pkg::T_DBL)
			return ra < rb ? tnvc_pkg::ORD_LESS :
				(ra > rb ? tnvc_pkg::ORD_GREATER : tnvc_pkg::ORD_EQUAL);
		if (a_t == tnvc_pkg::T_INT)
			return int_vs_real(longint'(a), rb);
		o = int_vs_real(longint'(b), ra);
		return o == tnvc_pkg::ORD_LESS ? tnvc_pkg::ORD_GREATER :
			(o == tnvc_pkg::ORD_GREATER ? tnvc_pkg::ORD_LESS : o);
	endfunction

	function automatic tnvc_pkg::result_t compare_values(input request_t r);
		tnvc_pkg::result_t res;
		tnvc_pkg::vtype_t a_t, b_t;
		bit a_num, b_num, has_nan;
		a_t = tnvc_pkg::vtype_t'(r.lt);
		b_t = tnvc_pkg::vtype_t'(r.rt);
		a_num = (a_t == tnvc_pkg::T_INT || a_t == tnvc_pkg::T_DBL);
		b_num = (b_t == tnvc_pkg::T_INT || b_t == tnvc_pkg::T_DBL);
		has_nan = (a_t == tnvc_pkg::T_DBL && nan_bits(r.lb))
			|| (b_t == tnvc_pkg::T_DBL && nan_bits(r.rb));
		res.order_code = tnvc_pkg::ORD_UNORDERED;
		res.is_equal = 1'b0;
		res.error_code = tnvc_pkg::ERR_NONE;
		if (r.action == tnvc_pkg::ACT_ORDER) begin
			if (a_t == tnvc_pkg::T_NULL || b_t == tnvc_pkg::T_NULL)
				res.order_code = tnvc_pkg::ORD_UNORDERED;
			else if (a_t == tnvc_pkg::T_BOOL || b_t == tnvc_pkg::T_BOOL)
				res.error_code = tnvc_pkg::ERR_INCOMPAT;
			else if (has_nan)
				res.error_code = tnvc_pkg::ERR_NAN;
			else
				res.order_code = order_of_numbers(a_t, r.lb, b_t, r.rb);
		end else begin
			if (a_t == tnvc_pkg::T_NULL && b_t == tnvc_pkg::T_NULL)
				res.is_equal = 1'b1;
			else if (a_t == tnvc_pkg::T_NULL || b_t == tnvc_pkg::T_NULL)
				res.is_equal = 1'b0;
			else if (a_num && b_num) begin
				if (has_nan)
					res.error_code = tnvc_pkg::ERR_NAN;
				else
					res.is_equal = order_of_numbers(a_t, r.lb, b_t, r.rb)
						== tnvc_pkg::ORD_EQUAL;
			end else if (a_t == tnvc_pkg::T_BOOL && b_t == tnvc_pkg::T_BOOL)
				res.is_equal = r.lb[0] == r.rb[0];
			else
				res.error_code = tnvc_pkg::ERR_INCOMPAT;
		end
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_payload(input tnvc_pkg::vtype_t t);
		case ($urandom_range(0, 4))
			0: return rand64();
			1: return 64'($signed($urandom_range(0, 40)) - 20);
			2: return $realtobits(real'($signed($urandom_range(0, 80)) - 40) / 4.0);
			3: begin
				case ($urandom_range(0, 9))
					0: return D_P63;
					1: return D_N63;
					2: return D_PINF;
					3: return D_NINF;
					4: return D_NZERO;
					5: return I_MAX;
					6: return I_MIN;
					7: return D_P53;
					8: return {D_QNAN[63:52], 52'($urandom())};
					default: return 64'd0;
				endcase
			end
			default: return t == tnvc_pkg::T_DBL ? {rand64()} >> $urandom_range(0, 12)
				: rand64();
		endcase
	endfunction

	task automatic add_req(input logic act, input tnvc_pkg::vtype_t a_t,
			input logic [63:0] a, input tnvc_pkg::vtype_t b_t, input logic [63:0] b);
		request_t r;
		r.action = act;
		r.lt = a_t;
		r.lb = a;
		r.rt = b_t;
		r.rb = b;
		r.drain = 0;
		pend_q.push_back(r);
	endtask

	task automatic add_random_req();
		tnvc_pkg::vtype_t a_t, b_t;
		logic [63:0] a, b;
		longint iv;
		logic act;
		act = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 2) == 0) begin
			// int against a nearby double, either side
			iv = longint'(rand64()) >>> $urandom_range(0, 62);
			a = iv;
			b = $realtobits(real'(iv));
			if ($urandom_range(0, 1))
				b = b + 64'($signed($urandom_range(0, 2)) - 1);
			if ($urandom_range(0, 1))
				add_req(act, tnvc_pkg::T_INT, a, tnvc_pkg::T_DBL, b);
			else
				add_req(act, tnvc_pkg::T_DBL, b, tnvc_pkg::T_INT, a);
		end else begin
			a_t = tnvc_pkg::vtype_t'($urandom_range(0, 3));
			b_t = tnvc_pkg::vtype_t'($urandom_range(0, 3));
			a = rand_payload(a_t);
			b = $urandom_range(0, 5) == 0 ? a : rand_payload(b_t);
			add_req(act, a_t, a, b_t, b);
		end
	endtask

	task automatic add_drain();
		request_t r;
		r = '{default: '0};
		r.drain = 1;
		pend_q.push_back(r);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		logic v;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			v = in_valid;
			if (in_valid && in_ready) begin
				r.action = action;
				r.lt = lhs_type;
				r.lb = lhs_bits;
				r.rt = rhs_type;
				r.rb = rhs_bits;
				expect_q.push_back(compare_values(r));
				n_sent++;
				v = 1'b0;
				if (n_sent < LATE_AT && $urandom_range(0, 7) == 0)
					in_gap = $urandom_range(1, 14);
			end
			if (!v) begin
				if (draining) begin
					if (expect_q.size() == 0)
						draining = 0;
				end else if (in_gap > 0) begin
					in_gap--;
				end else if (pend_q.size() > 0) begin
					r = pend_q.pop_front();
					if (r.drain) begin
						draining = 1;
					end else begin
						action <= r.action;
						lhs_type <= r.lt;
						lhs_bits <= r.lb;
						rhs_type <= r.rt;
						rhs_bits <= r.rb;
						v = 1'b1;
					end
				end
			end
			in_valid <= v;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		tnvc_pkg::result_t e;
		logic rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_got++;
				if (expect_q.size() == 0) begin
					$error("result with no request outstanding");
					n_err++;
				end else begin
					e = expect_q.pop_front();
					if (order_code !== e.order_code) begin
						$error("order_code: expected %0d, got %0d", e.order_code, order_code);
						n_err++;
					end
					if (is_equal !== e.is_equal) begin
						$error("is_equal: expected %0d, got %0d", e.is_equal, is_equal);
						n_err++;
					end
					if (error_code !== e.error_code) begin
						$error("error_code: expected %0d, got %0d", e.error_code, error_code);
						n_err++;
					end
					n_nan += (e.error_code == tnvc_pkg::ERR_NAN);
					n_incompat += (e.error_code == tnvc_pkg::ERR_INCOMPAT);
					n_eqtrue += e.is_equal;
				end
				if (n_got == 120)
					out_hold = 150;
			end
			if (out_hold > 0) begin
				out_hold--;
				rdy = 1'b0;
			end else if (n_got < LATE_AT && $urandom_range(0, 9) == 0) begin
				out_hold = $urandom_range(1, 14) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ready <= rdy;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_INT, 64'd5, tnvc_pkg::T_INT, 64'd7);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_INT, I_MIN, tnvc_pkg::T_INT, I_MAX);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_DBL, D_NZERO, tnvc_pkg::T_DBL, 64'd0);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_DBL, D_NZERO, tnvc_pkg::T_INT, 64'd0);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_INT, I_MIN, tnvc_pkg::T_DBL, D_N63);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_INT, I_MIN, tnvc_pkg::T_DBL, D_N63);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_INT, I_MAX, tnvc_pkg::T_DBL, D_P63);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_DBL, D_NINF, tnvc_pkg::T_INT, I_MIN);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_INT, 64'd1, tnvc_pkg::T_DBL, D_1P5);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_DBL, D_NEG1P5, tnvc_pkg::T_INT, -64'sd1);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_INT, 64'h0020_0000_0000_0001,
			tnvc_pkg::T_DBL, D_P53);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_INT, 64'h0020_0000_0000_0001,
			tnvc_pkg::T_DBL, D_P53);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_NULL, 64'd0, tnvc_pkg::T_BOOL, 64'd1);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_DBL, D_QNAN, tnvc_pkg::T_NULL, 64'd0);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_BOOL, 64'd0, tnvc_pkg::T_INT, 64'd3);
		add_req(tnvc_pkg::ACT_ORDER, tnvc_pkg::T_DBL, D_PINF, tnvc_pkg::T_DBL,
			64'hFFFF_FFFF_FFFF_FFFF);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_INT, 64'd3, tnvc_pkg::T_DBL, D_QNAN);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_NULL, 64'd9, tnvc_pkg::T_NULL,
			64'hFFFF_FFFF_FFFF_FFFF);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_NULL, 64'd0, tnvc_pkg::T_INT, 64'd0);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_BOOL, 64'hFFFF_FFFF_FFFF_FFFE,
			tnvc_pkg::T_BOOL, 64'd0);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_BOOL, 64'd1, tnvc_pkg::T_BOOL,
			64'hFFFF_FFFF_FFFF_FFFF);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_BOOL, 64'd1, tnvc_pkg::T_DBL,
			64'h3FF0_0000_0000_0000);
		add_req(tnvc_pkg::ACT_EQUAL, tnvc_pkg::T_DBL, D_PINF, tnvc_pkg::T_DBL, D_PINF);
		add_drain();
		repeat (200)
			add_random_req();
		add_drain();
		repeat (200)
			add_random_req();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pend_q.size() > 0 || in_valid || draining || expect_q.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d results from %0d requests: %0d NaN, %0d incompatible, %0d equal.",
			n_got, n_sent, n_nan, n_incompat, n_eqtrue);
		if (n_err == 0 && expect_q.size() == 0 && !out_valid)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
